// ===== rtl/core/pso_pkg.sv =====
package pso_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned MAX_VOICES_DEF = 16;
  localparam int unsigned PHASE_BITS_DEF = 24;

  // Sample rate the pitch table is built for
  localparam int unsigned SAMPLE_RATE = 48000;

  // Register file
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 17;
  localparam logic [CFG_IDX_W-1:0] REG_MIX  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN = 1'd1;
  localparam logic [CFG_W-1:0] Q16_ONE   = 17'd65536;
  localparam logic [CFG_W-1:0] MIX_RST   = 17'd0;
  localparam logic [CFG_W-1:0] GAIN_RST  = 17'd32768;

  // Input decode
  localparam logic       FUNC_TICK     = 1'b0;
  localparam logic [3:0] MIDI_NOTE_OFF = 4'h8;
  localparam logic [3:0] MIDI_NOTE_ON  = 4'h9;

  localparam int unsigned KEY_W    = 7;
  localparam int unsigned SAMPLE_W = 28;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_TICK,
    OP_NOTE_ON,
    OP_NOTE_OFF
  } op_e;

  typedef struct packed {
    op_e  op;
    logic capture;
    logic clr_acc;
    logic rd;
    logic alloc;
    logic drop;
    logic mul_lo;
    logic mul_hi;
    logic sum;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic voice_free;
  } dp_stat_t;

  // Octave-0 note frequencies, Q16
  localparam logic [20:0] OCT0_FREQ_Q16 [12] = '{
    21'd1071645, 21'd1135368, 21'd1202880, 21'd1274407, 21'd1350188, 21'd1430474,
    21'd1515534, 21'd1605653, 21'd1701130, 21'd1802284, 21'd1909454, 21'd2022996
  };

  localparam logic [63:0] STEP_DEN = 64'(SAMPLE_RATE) << 16;

  typedef logic [63:0] step_rom_t [128];

  // Elaboration-time pitch table: round(f * 2^pb / fs), f in Q16
  function automatic step_rom_t build_step_rom(int unsigned pb);
    step_rom_t   rom;
    logic [63:0] f;
    logic [63:0] num;
    int unsigned k;
    k = 0;
    for (int oct = 0; oct < 11; oct++) begin
      for (int n = 0; n < 12; n++) begin
        if (k < 128) begin
          f      = 64'(OCT0_FREQ_Q16[n]) << oct;
          num    = (f << pb) + STEP_DEN / 2;
          rom[k] = num / STEP_DEN;
          k      = k + 1;
        end
      end
    end
    return rom;
  endfunction

endpackage

// ===== rtl/core/pso_ctrl.sv =====
module pso_ctrl #(
  parameter int unsigned MAX_VOICES = pso_pkg::MAX_VOICES_DEF,
  localparam int unsigned IdxW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             func_i,
  input  logic [7:0]       status_byte_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  pso_pkg::dp_stat_t stat_i,
  output pso_pkg::dp_cmd_t  cmd_o,
  output logic [IdxW-1:0]  idx_o
);
  import pso_pkg::*;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(MAX_VOICES - 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIND,
    ST_WALK,
    ST_DRAIN1,
    ST_DRAIN2,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SUM,
    ST_OUT
  } state_e;

  state_e          state_q;
  op_e             op_q;
  logic [IdxW-1:0] idx_q;
  logic            out_valid_q;

  logic in_accept;
  op_e  in_op;
  logic out_free;

  always_comb begin
    priority if (func_i == FUNC_TICK) begin
      in_op = OP_TICK;
    end else if (status_byte_i[7:4] == MIDI_NOTE_ON) begin
      in_op = OP_NOTE_ON;
    end else if (status_byte_i[7:4] == MIDI_NOTE_OFF) begin
      in_op = OP_NOTE_OFF;
    end else begin
      in_op = OP_NONE;
    end
  end

  assign in_accept = in_valid_i && (state_q == ST_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o          = '0;
    cmd_o.op       = op_q;
    cmd_o.capture  = in_accept;
    cmd_o.clr_acc  = in_accept && (in_op == OP_TICK);
    cmd_o.rd       = (state_q == ST_WALK);
    cmd_o.alloc    = (state_q == ST_FIND) && stat_i.voice_free;
    cmd_o.drop     = (state_q == ST_FIND) && !stat_i.voice_free && (idx_q == LastIdx);
    cmd_o.mul_lo   = (state_q == ST_MUL_LO);
    cmd_o.mul_hi   = (state_q == ST_MUL_HI);
    cmd_o.sum      = (state_q == ST_SUM);
    cmd_o.load_out = (state_q == ST_OUT) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_NONE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            op_q  <= in_op;
            idx_q <= '0;
            unique case (in_op)
              OP_TICK, OP_NOTE_OFF: state_q <= ST_WALK;
              OP_NOTE_ON:           state_q <= ST_FIND;
              OP_NONE:              state_q <= ST_IDLE;
            endcase
          end
        end
        ST_FIND: begin
          // lowest free voice wins; walking off the end drops the note
          if (stat_i.voice_free || (idx_q == LastIdx)) begin
            state_q <= ST_IDLE;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        ST_WALK: begin
          if (idx_q == LastIdx) begin
            state_q <= ST_DRAIN1;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        ST_DRAIN1: state_q <= (op_q == OP_TICK) ? ST_DRAIN2 : ST_IDLE;
        ST_DRAIN2: state_q <= ST_MUL_LO;
        ST_MUL_LO: state_q <= ST_MUL_HI;
        ST_MUL_HI: state_q <= ST_SUM;
        ST_SUM:    state_q <= ST_OUT;
        ST_OUT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign idx_o       = idx_q;

endmodule

// ===== rtl/core/pso_datapath.sv =====
module pso_datapath #(
  parameter int unsigned MAX_VOICES = pso_pkg::MAX_VOICES_DEF,
  parameter int unsigned PHASE_BITS = pso_pkg::PHASE_BITS_DEF,
  localparam int unsigned IdxW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pso_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pso_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic [pso_pkg::KEY_W-1:0]         key_number_i,
  input  pso_pkg::dp_cmd_t                  cmd_i,
  input  logic [IdxW-1:0]                   idx_i,
  output pso_pkg::dp_stat_t                 stat_o,
  output logic signed [pso_pkg::SAMPLE_W-1:0] sample_out_o,
  output logic                              notes_dropped_o
);
  import pso_pkg::*;

  localparam int unsigned PB    = PHASE_BITS;
  localparam int unsigned MemW  = KEY_W + 2 * PB;
  localparam int unsigned TermW = 42;
  localparam int unsigned AccW  = TermW + $clog2(MAX_VOICES);
  localparam int unsigned HiW   = AccW - 23;
  localparam int unsigned PhiW  = HiW + 18;
  localparam int unsigned ProdW = AccW + 19;
  localparam int unsigned SW    = ProdW - 32;

  localparam step_rom_t StepRom = build_step_rom(PB);

  localparam logic signed [SW-1:0] SatHi = SW'(134217727);
  localparam logic signed [SW-1:0] SatLo = SW'(-134217728);

  // Config registers, stored already clamped to unity
  logic [CFG_W-1:0] mix_q, gain_q;
  logic [CFG_W-1:0] cfg_clamped;

  assign cfg_clamped = (cfg_data_i > Q16_ONE) ? Q16_ONE : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mix_q  <= MIX_RST;
      gain_q <= GAIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_MIX:  mix_q  <= cfg_clamped;
        REG_GAIN: gain_q <= cfg_clamped;
        default: ;
      endcase
    end
  end

  logic [KEY_W-1:0] key_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      key_q <= key_number_i;
    end
  end

  // Voice store: {key, step, phase}, one read and one write per cycle
  logic [MemW-1:0] voice_mem [MAX_VOICES];
  logic [MemW-1:0] rd_data_q;
  logic [IdxW-1:0] s1_idx_q;
  logic            s1_vld_q;
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  logic [MemW-1:0] mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      voice_mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.rd) begin
      rd_data_q <= voice_mem[idx_i];
      s1_idx_q  <= idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= cmd_i.rd;
    end
  end

  logic [KEY_W-1:0] rd_key;
  logic [PB-1:0]    rd_step, rd_phase, new_step;
  logic             s1_act, tick_hit, off_hit;

  assign rd_key   = rd_data_q[MemW-1 -: KEY_W];
  assign rd_step  = rd_data_q[2*PB-1 -: PB];
  assign rd_phase = rd_data_q[PB-1:0];
  assign new_step = StepRom[key_q][PB-1:0];

  logic [MAX_VOICES-1:0] active_q, active_d;

  assign s1_act   = active_q[s1_idx_q];
  assign tick_hit = s1_vld_q && (cmd_i.op == OP_TICK) && s1_act;
  assign off_hit  = s1_vld_q && (cmd_i.op == OP_NOTE_OFF) && s1_act && (rd_key == key_q);

  assign mem_we    = cmd_i.alloc || tick_hit;
  assign mem_waddr = cmd_i.alloc ? idx_i : s1_idx_q;
  assign mem_wdata = cmd_i.alloc ? {key_q, new_step, {PB{1'b0}}}
                                 : {rd_key, rd_step, rd_phase + rd_step};

  always_comb begin
    active_d = active_q;
    if (cmd_i.alloc) begin
      active_d[idx_i] = 1'b1;
    end
    if (off_hit) begin
      active_d[s1_idx_q] = 1'b0;
    end
  end

  logic dropped_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= '0;
      dropped_q <= 1'b0;
    end else begin
      active_q <= active_d;
      if (cmd_i.drop) begin
        dropped_q <= 1'b1;
      end else if (cmd_i.load_out) begin
        dropped_q <= 1'b0;
      end
    end
  end

  assign stat_o.voice_free = !active_q[idx_i];

  // Per-voice term: mix*square + (1-mix)*saw
  logic [PB+23:0]            ph_ext;
  logic [23:0]               p24;
  logic signed [23:0]        saw;
  logic                      sqr_pos;
  logic [CFG_W-1:0]          coef;
  logic [TermW-1:0]          sq_mag;
  logic signed [TermW-1:0]   mul_d, sq_d, mul_q, sq_q;
  logic                      term_vld_q;

  assign ph_ext  = {rd_phase, 24'b0};
  assign p24     = ph_ext[PB+23:PB];
  assign saw     = $signed({~p24[23], p24[22:0]});
  assign sqr_pos = rd_phase[PB-1] && (|rd_phase[PB-2:0]);
  assign coef    = Q16_ONE - mix_q;
  assign sq_mag  = {2'b00, mix_q, 23'b0};
  assign mul_d   = $signed({1'b0, coef}) * saw;
  assign sq_d    = sqr_pos ? $signed(sq_mag) : -$signed(sq_mag);

  always_ff @(posedge clk_i) begin
    if (tick_hit) begin
      mul_q <= mul_d;
      sq_q  <= sq_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_vld_q <= 1'b0;
    end else begin
      term_vld_q <= tick_hit;
    end
  end

  logic signed [AccW-1:0] acc_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_acc) begin
      acc_q <= '0;
    end else if (term_vld_q) begin
      acc_q <= acc_q + AccW'(mul_q) + AccW'(sq_q);
    end
  end

  // Gain: acc split at bit 23 into two partial products
  logic [39:0]             plo_d, plo_q;
  logic signed [PhiW-1:0]  phi_d, phi_q;
  logic [ProdW-1:0]        v_d, v_q;

  assign plo_d = acc_q[22:0] * gain_q;
  assign phi_d = $signed(acc_q[AccW-1:23]) * $signed({1'b0, gain_q});
  assign v_d   = (ProdW'(phi_q) << 23) + ProdW'(plo_q) + (ProdW'(1) << 31);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_lo) begin
      plo_q <= plo_d;
    end
    if (cmd_i.mul_hi) begin
      phi_q <= phi_d;
    end
    if (cmd_i.sum) begin
      v_q <= v_d;
    end
  end

  // Floor shift, then saturate
  logic signed [SW-1:0]       s_full;
  logic signed [SAMPLE_W-1:0] s_sat;

  assign s_full = $signed(v_q[ProdW-1:32]);

  always_comb begin
    priority if (s_full > SatHi) begin
      s_sat = SAMPLE_W'(SatHi);
    end else if (s_full < SatLo) begin
      s_sat = SAMPLE_W'(SatLo);
    end else begin
      s_sat = s_full[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      sample_out_o    <= s_sat;
      notes_dropped_o <= dropped_q;
    end
  end

endmodule

// ===== rtl/core/poly_saw_square_oscillator_unit.sv =====
// Channel | Direction | Handshake                 | Payload
// in      | input     | in_valid_i / in_stall_o   | func_i, status_byte_i, key_number_i
// out     | output    | out_valid_o / out_stall_i | sample_out_o, notes_dropped_o
// cfg     | input     | cfg_we_i                  | cfg_index_i, cfg_data_i
//
// Sample tick: result set by the walk over the voice store (one read port, one voice per cycle)
// plus drain, two gain partial products, rounding and output load; the next transaction is
// taken after the output load, which waits while an earlier result is stalled. Note-off: a
// walk over every voice plus drain per transaction. Note-on: searching voices in order,
// stopping at the first free one. Other messages: taken without leaving idle.
// Reset clears voice active bits, the dropped flag and the config and control registers; no clearing pass.
// A stalled result waits in the output register; the next transaction is still taken.
module poly_saw_square_oscillator_unit #(
  parameter int unsigned MAX_VOICES = pso_pkg::MAX_VOICES_DEF,
  parameter int unsigned PHASE_BITS = pso_pkg::PHASE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pso_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [pso_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                func_i,
  input  logic [7:0]                          status_byte_i,
  input  logic [pso_pkg::KEY_W-1:0]           key_number_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [pso_pkg::SAMPLE_W-1:0] sample_out_o,
  output logic                                notes_dropped_o
);
  import pso_pkg::*;

  localparam int unsigned IdxW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;

  dp_cmd_t         cmd;
  dp_stat_t        stat;
  logic [IdxW-1:0] idx;

  pso_ctrl #(
    .MAX_VOICES(MAX_VOICES)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .status_byte_i(status_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .stat_i       (stat),
    .cmd_o        (cmd),
    .idx_o        (idx)
  );

  pso_datapath #(
    .MAX_VOICES(MAX_VOICES),
    .PHASE_BITS(PHASE_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .key_number_i   (key_number_i),
    .cmd_i          (cmd),
    .idx_i          (idx),
    .stat_o         (stat),
    .sample_out_o   (sample_out_o),
    .notes_dropped_o(notes_dropped_o)
  );

  // never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> !(out_valid_o && out_stall_i))
    else $error("result overwritten while stalled");

  a_valid_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.load_out))
    else $error("result valid without output load");

  a_alloc_xor_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.alloc && cmd.drop))
    else $error("note both stored and dropped");

  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (func_i == FUNC_TICK)) |=> in_stall_o)
    else $error("tick transaction did not start the voice walk");

endmodule

// ===== test/testbench.sv =====
module testbench;
  import pso_pkg::*;

  localparam int NV      = MAX_VOICES_DEF;
  localparam int PHASE_W = PHASE_BITS_DEF;
  localparam int DRAIN_CYCLES = 2 * NV + 16;
  localparam int HOLD_CYCLES  = 300;

  localparam logic       FUNC_MIDI         = ~FUNC_TICK;
  localparam logic [3:0] MIDI_KEY_PRESSURE = 4'hA;

  localparam longint HALF_SCALE = longint'(1) << 23;
  localparam longint ROUND_HALF = longint'(1) << 31;
  localparam longint Q16_UNITY  = longint'(Q16_ONE);
  localparam longint SAMPLE_MAX = (longint'(1) << (SAMPLE_W - 1)) - 1;
  localparam longint SAMPLE_MIN = -(longint'(1) << (SAMPLE_W - 1));
  localparam logic [PHASE_W-1:0] PHASE_HALF = {1'b1, {(PHASE_W - 1){1'b0}}};
  localparam logic [63:0] PITCH_DEN = 64'(SAMPLE_RATE) << 16;

  // C0..B0 in Q16 Hz; higher octaves are shifts of these
  localparam logic [20:0] NOTE_FREQ_Q16 [12] = '{
    21'd1071645, 21'd1135368, 21'd1202880, 21'd1274407, 21'd1350188, 21'd1430474,
    21'd1515534, 21'd1605653, 21'd1701130, 21'd1802284, 21'd1909454, 21'd2022996
  };

  typedef enum logic [1:0] {
    DRV_FETCH,
    DRV_GAP,
    DRV_OFFER,
    DRV_DRAIN
  } drv_state_e;

  typedef struct {
    bit                   is_cfg;
    logic                 func;
    logic [7:0]           status;
    logic [KEY_W-1:0]     key;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]     reg_val;
    int                   gap;
  } stim_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       dropped;
  } sample_rec_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic func_i = 1'b0;
  logic [7:0] status_byte_i = '0;
  logic [KEY_W-1:0] key_number_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_out_o;
  logic notes_dropped_o;

  poly_saw_square_oscillator_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .status_byte_i  (status_byte_i),
    .key_number_i   (key_number_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .sample_out_o   (sample_out_o),
    .notes_dropped_o(notes_dropped_o)
  );

  // Voice bank as the checker sees it
  bit                 osc_busy [NV];
  logic [KEY_W-1:0]   osc_key [NV];
  logic [PHASE_W-1:0] osc_inc [NV];
  logic [PHASE_W-1:0] osc_phase [NV];
  bit                 drop_seen;
  logic [CFG_W-1:0]   mix_q16;
  logic [CFG_W-1:0]   gain_q16;

  stim_t       stimulus [$];
  sample_rec_t expected_samples [$];
  int          sounding_keys [$];

  drv_state_e drv_state = DRV_FETCH;
  stim_t      cur;
  int         gap_left;
  int         quiet_left;
  bit         tx_calm;
  bit         item_taken;
  bit         out_taken;
  bit         out_seen;
  int         rx_wait;
  int         hold_left;
  int         samples_checked;
  int         failures;

  task automatic add_item(input logic f, input logic [7:0] st, input logic [KEY_W-1:0] k);
    stim_t s;
    s.is_cfg = 1'b0;
    s.func   = f;
    s.status = st;
    s.key    = k;
    s.gap    = tx_calm ? 0 : $urandom_range(0, 7);
    stimulus = {stimulus, s};
  endtask

  task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    stim_t s;
    s.is_cfg  = 1'b1;
    s.reg_idx = idx;
    s.reg_val = val;
    stimulus = {stimulus, s};
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  // Driver: presents one transaction at a time, config writes only once drained
  always @(negedge clk_i) begin
    logic nxt_valid;
    logic nxt_we;
    nxt_valid = in_valid_i;
    nxt_we    = 1'b0;
    if (rst_ni) begin
      if (drv_state == DRV_OFFER && item_taken) begin
        nxt_valid = 1'b0;
        drv_state = DRV_FETCH;
      end
      if (drv_state == DRV_FETCH && stimulus.size() > 0) begin
        cur = stimulus.pop_front();
        if (cur.is_cfg) begin
          drv_state  = DRV_DRAIN;
          quiet_left = DRAIN_CYCLES;
        end else begin
          drv_state = DRV_GAP;
          gap_left  = cur.gap;
        end
      end
      if (drv_state == DRV_GAP) begin
        if (gap_left == 0) begin
          nxt_valid = 1'b1;
          func_i        <= cur.func;
          status_byte_i <= cur.status;
          key_number_i  <= cur.key;
          drv_state = DRV_OFFER;
        end else begin
          gap_left--;
        end
      end
      if (drv_state == DRV_DRAIN) begin
        if (expected_samples.size() != 0) begin
          quiet_left = DRAIN_CYCLES;
        end else if (quiet_left == 0) begin
          nxt_we = 1'b1;
          cfg_index_i <= cur.reg_idx;
          cfg_data_i  <= cur.reg_val;
          drv_state = DRV_FETCH;
        end else begin
          quiet_left--;
        end
      end
    end
    in_valid_i <= nxt_valid;
    cfg_we_i   <= nxt_we;
  end

  // Receiver: random stalls per result, calm stretches, two long hold-offs
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken) begin
        rx_wait = ((samples_checked / 40) % 3 == 1) ? 0 : $urandom_range(0, 7);
        if (samples_checked == 100 || samples_checked == 350) hold_left = HOLD_CYCLES;
      end else if (out_seen && rx_wait > 0) begin
        rx_wait--;
      end
      if (hold_left > 0) hold_left--;
      out_stall_i <= (hold_left > 0) || (rx_wait > 0);
    end
  end

  // Monitor: checks results, tracks config writes and predicts accepted transactions
  always @(posedge clk_i) begin
    sample_rec_t want;
    longint mix_l;
    longint gain_l;
    longint acc;
    longint saw;
    longint sqr;
    longint v;
    logic [63:0] freq;
    logic [63:0] num;
    int slot;
    out_taken  = 1'b0;
    item_taken = 1'b0;
    out_seen   = 1'b0;
    if (rst_ni) begin
      out_seen = out_valid_o;
      if (out_valid_o && !out_stall_i) begin
        out_taken = 1'b1;
        samples_checked++;
        if (expected_samples.size() == 0) begin
          $error("unexpected result: sample_out %0d notes_dropped %0b",
                 sample_out_o, notes_dropped_o);
          failures++;
        end else begin
          want = expected_samples.pop_front();
          if (sample_out_o !== want.sample) begin
            $error("sample_out: expected %0d, got %0d", $signed(want.sample), sample_out_o);
            failures++;
          end
          if (notes_dropped_o !== want.dropped) begin
            $error("notes_dropped: expected %0b, got %0b", want.dropped, notes_dropped_o);
            failures++;
          end
        end
      end

      if (cfg_we_i) begin
        if (cfg_index_i == REG_MIX) mix_q16 = cfg_data_i;
        else if (cfg_index_i == REG_GAIN) gain_q16 = cfg_data_i;
      end

      if (in_valid_i && !in_stall_o) begin
        item_taken = 1'b1;
        if (func_i != FUNC_TICK) begin
          if (status_byte_i[7:4] == MIDI_NOTE_OFF) begin
            for (int i = 0; i < NV; i++)
              if (osc_busy[i] && osc_key[i] == key_number_i) osc_busy[i] = 1'b0;
          end else if (status_byte_i[7:4] == MIDI_NOTE_ON) begin
            slot = -1;
            for (int i = NV - 1; i >= 0; i--)
              if (!osc_busy[i]) slot = i;
            if (slot < 0) begin
              drop_seen = 1'b1;
            end else begin
              // step = round(f * 2^PHASE_W / fs), f in Q16
              freq = 64'(NOTE_FREQ_Q16[key_number_i % 12]) << (key_number_i / 12);
              num  = (freq << PHASE_W) + PITCH_DEN / 2;
              osc_busy[slot]  = 1'b1;
              osc_key[slot]   = key_number_i;
              osc_inc[slot]   = PHASE_W'(num / PITCH_DEN);
              osc_phase[slot] = '0;
            end
          end
        end else begin
          mix_l  = (mix_q16 > Q16_ONE) ? Q16_UNITY : longint'(mix_q16);
          gain_l = (gain_q16 > Q16_ONE) ? Q16_UNITY : longint'(gain_q16);
          acc = 0;
          for (int i = 0; i < NV; i++) begin
            if (osc_busy[i]) begin
              saw = ((longint'(osc_phase[i]) << 24) >>> PHASE_W) - HALF_SCALE;
              sqr = (osc_phase[i] > PHASE_HALF) ? HALF_SCALE : -HALF_SCALE;
              acc += mix_l * sqr + (Q16_UNITY - mix_l) * saw;
              osc_phase[i] = osc_phase[i] + osc_inc[i];
            end
          end
          // round half up, then clip to the output range
          v = (acc * gain_l + ROUND_HALF) >>> 32;
          if (v > SAMPLE_MAX) v = SAMPLE_MAX;
          else if (v < SAMPLE_MIN) v = SAMPLE_MIN;
          want.sample  = SAMPLE_W'(v);
          want.dropped = drop_seen;
          drop_seen = 1'b0;
          expected_samples = {expected_samples, want};
        end
      end
    end
  end

  initial begin
    logic [CFG_W-1:0] mix_plan [7];
    logic [CFG_W-1:0] gain_plan [7];
    int pick;
    int k;

    for (int i = 0; i < NV; i++) osc_busy[i] = 1'b0;
    drop_seen = 1'b0;
    mix_q16   = MIX_RST;
    gain_q16  = GAIN_RST;

    // Reset-time registers: single voice, ignored and stray messages
    add_item(FUNC_MIDI, {MIDI_NOTE_ON, 4'hF}, 7'd127);
    add_item(FUNC_TICK, 8'h00, 7'd0);
    add_item(FUNC_MIDI, {MIDI_NOTE_OFF, 4'h0}, 7'd5);
    add_item(FUNC_MIDI, {MIDI_KEY_PRESSURE, 4'h0}, 7'h55);
    add_item(FUNC_MIDI, {MIDI_NOTE_OFF, 4'hF}, 7'd127);
    add_item(FUNC_TICK, 8'hFF, 7'd127);

    // Full square at unity gain: all voices on one key, then an overflowing
    // note-on, then ticks until the phases pass one half and the output clips
    add_cfg(REG_MIX, Q16_ONE);
    add_cfg(REG_GAIN, Q16_ONE);
    for (int i = 0; i < NV; i++) add_item(FUNC_MIDI, {MIDI_NOTE_ON, 4'(i)}, 7'd120);
    add_item(FUNC_MIDI, {MIDI_NOTE_ON, 4'h3}, 7'd0);
    repeat (3) add_item(FUNC_TICK, 8'h00, 7'd0);

    mix_plan[0] = '0;                  gain_plan[0] = Q16_ONE;
    mix_plan[1] = Q16_ONE;             gain_plan[1] = '0;
    mix_plan[2] = '1;                  gain_plan[2] = '1;
    mix_plan[3] = 17'd32768;           gain_plan[3] = Q16_ONE;
    mix_plan[4] = CFG_W'($urandom);    gain_plan[4] = CFG_W'($urandom);
    mix_plan[5] = 17'd65535;           gain_plan[5] = 17'd1;
    mix_plan[6] = CFG_W'($urandom_range(0, 65536));
    gain_plan[6] = CFG_W'($urandom_range(0, 65536));

    for (int p = 0; p < 7; p++) begin
      add_cfg(REG_MIX, mix_plan[p]);
      add_cfg(REG_GAIN, gain_plan[p]);
      if (p == 0) add_item(FUNC_MIDI, {MIDI_NOTE_OFF, 4'h0}, 7'd120);
      for (int n = 0; n < 200; n++) begin
        tx_calm = ((n / 40) % 3 == 2);
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          add_item(FUNC_TICK, 8'($urandom), KEY_W'($urandom));
        end else if (pick < 68) begin
          if (sounding_keys.size() > 0 && $urandom_range(0, 3) == 0)
            k = sounding_keys[$urandom_range(0, sounding_keys.size() - 1)];
          else
            k = $urandom_range(0, 127);
          sounding_keys = {sounding_keys, k};
          add_item(FUNC_MIDI, {MIDI_NOTE_ON, 4'($urandom)}, KEY_W'(k));
        end else if (pick < 94) begin
          if (sounding_keys.size() > 0 && $urandom_range(0, 4) != 0)
            k = sounding_keys[$urandom_range(0, sounding_keys.size() - 1)];
          else
            k = $urandom_range(0, 127);
          sounding_keys = sounding_keys.find(x) with (x != k);
          add_item(FUNC_MIDI, {MIDI_NOTE_OFF, 4'($urandom)}, KEY_W'(k));
        end else begin
          add_item(FUNC_MIDI, 8'($urandom), KEY_W'($urandom));
        end
      end
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (!(drv_state == DRV_FETCH && stimulus.size() == 0 &&
             expected_samples.size() == 0))
      @(posedge clk_i);
    repeat (3 * NV) @(posedge clk_i);
    @(negedge clk_i);
    if (expected_samples.size() != 0) begin
      $error("%0d samples never arrived", expected_samples.size());
      failures++;
    end
    if (failures == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/pso_pkg.sv
rtl/core/pso_ctrl.sv
rtl/core/pso_datapath.sv
rtl/core/poly_saw_square_oscillator_unit.sv
test/testbench.sv
